// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl of the averaging temperature lcd writer
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ----- rtl/core/adcavg_pkg.sv -----
// shared types, widths and constants of the averaging temperature lcd writer
// no dependencies; imported by every module of the block
package adcavg_pkg;

   // sample averaging
   localparam int AVG_LOG2    = 4;
   localparam int SAMPLE_BITS = 10;
   localparam int SUM_W       = SAMPLE_BITS + AVG_LOG2;

   // scaling
   localparam int SCALE_W     = 10;
   localparam int SCALE_SHIFT = 10;
   localparam int PROD_W      = SAMPLE_BITS + SCALE_W;
   localparam int TEMP_W      = 10;
   localparam int TEMP_MAX    = 1023;
   localparam int DISP_W      = 7;
   localparam logic [DISP_W-1:0] DISPLAY_MAX = 7'd99;

   // configuration registers
   localparam int CURSOR_W    = 7;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = SCALE_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_ADDRESS = 8'd1;
   localparam logic [SCALE_W-1:0]     SCALE_RESET        = 10'd300;
   localparam logic [CURSOR_W-1:0]    CURSOR_RESET       = 7'd70;

   // stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int BYTE_W     = 8;

   // lcd burst: seven beats
   localparam int BYTE_IDX_W = 3;
   localparam logic [BYTE_IDX_W-1:0] BYTE_CMD    = 3'd0;
   localparam logic [BYTE_IDX_W-1:0] BYTE_TENS   = 3'd1;
   localparam logic [BYTE_IDX_W-1:0] BYTE_ONES   = 3'd2;
   localparam logic [BYTE_IDX_W-1:0] BYTE_SPACE  = 3'd3;
   localparam logic [BYTE_IDX_W-1:0] BYTE_OPEN   = 3'd4;
   localparam logic [BYTE_IDX_W-1:0] BYTE_LETTER = 3'd5;
   localparam logic [BYTE_IDX_W-1:0] BYTE_CLOSE  = 3'd6;

   localparam logic [BYTE_W-1:0] LCD_SET_CURSOR = 8'h80;
   localparam logic [BYTE_W-1:0] CHAR_ZERO      = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_OPEN      = 8'h28;
   localparam logic [BYTE_W-1:0] CHAR_C         = 8'h43;
   localparam logic [BYTE_W-1:0] CHAR_CLOSE     = 8'h29;

   // one pending display update
   typedef struct packed {
      logic [DISP_W-1:0]   temperature;
      logic [CURSOR_W-1:0] cursor;
   } burst_type;

   // tens digit of 0..99 by reciprocal multiply (205 / 2048)
   function automatic logic [3:0] tens_digit(input logic [DISP_W-1:0] value);
      logic [DISP_W+7:0] prod;
      prod = (DISP_W+8)'(value) * (DISP_W+8)'(205);
      return prod[14:11];
   endfunction

endpackage

// ----- rtl/core/adcavg_front.sv -----
// front end: accumulates samples, scales each block average and decides on a burst
// depends on adcavg_pkg; feeds adcavg_queue
module adcavg_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [adcavg_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [adcavg_pkg::SCALE_W-1:0]      scale_factor,
   input  logic [adcavg_pkg::CURSOR_W-1:0]     cursor_address,
   output logic                                push_valid,
   output adcavg_pkg::burst_type               push_entry,
   input  logic                                queue_full
);
   import adcavg_pkg::*;

   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [AVG_LOG2-1:0]    count_ff, count_in;
   logic                   a_valid_ff, a_valid_in;
   logic                   a_end_ff, a_end_in;
   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [TEMP_W-1:0]      cur_ff, cur_in;
   logic [DISP_W-1:0]      shown_ff, shown_in;

   logic                   accept;
   logic [SUM_W-1:0]       total;
   logic                   block_end;
   logic [PROD_W-1:0]      prod;
   logic [PROD_W-1:0]      scaled;
   logic [TEMP_W-1:0]      new_temp;
   logic [DISP_W-1:0]      disp;
   logic                   change;
   logic                   a_fire;

   // stage a: accumulate and capture the block average
   assign accept    = req_tvalid & req_tready;
   assign total     = sum_ff + SUM_W'(req_tdata[SAMPLE_BITS-1:0]);
   assign block_end = &count_ff;

   // stage b: scale, saturate and compare with the shown value
   assign prod     = PROD_W'(avg_ff) * PROD_W'(scale_factor);
   assign scaled   = prod >> SCALE_SHIFT;
   assign new_temp = !a_end_ff ? cur_ff :
                     (scaled > PROD_W'(TEMP_MAX)) ? TEMP_W'(TEMP_MAX) : scaled[TEMP_W-1:0];
   assign disp     = (new_temp > TEMP_W'(DISPLAY_MAX)) ? DISPLAY_MAX : new_temp[DISP_W-1:0];
   assign change   = disp != shown_ff;
   assign a_fire   = a_valid_ff & (~change | ~queue_full);

   assign req_tready             = ~a_valid_ff | a_fire;
   assign push_valid             = a_valid_ff & change & ~queue_full;
   assign push_entry.temperature = disp;
   assign push_entry.cursor      = cursor_address;

   // next state
   always_comb begin
      sum_in     = sum_ff;
      count_in   = count_ff;
      a_valid_in = a_valid_ff;
      a_end_in   = a_end_ff;
      avg_in     = avg_ff;
      cur_in     = cur_ff;
      shown_in   = shown_ff;
      if (a_fire) begin
         a_valid_in = 1'b0;
         cur_in     = new_temp;
         shown_in   = disp;
      end
      if (accept) begin
         a_valid_in = 1'b1;
         a_end_in   = block_end;
         avg_in     = total[SUM_W-1:AVG_LOG2];
         sum_in     = block_end ? '0 : total;
         count_in   = count_ff + 1'b1;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         count_ff   <= '0;
         a_valid_ff <= 1'b0;
         cur_ff     <= '0;
         shown_ff   <= '0;
      end else begin
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         a_valid_ff <= a_valid_in;
         cur_ff     <= cur_in;
         shown_ff   <= shown_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_end_ff <= a_end_in;
      avg_ff   <= avg_in;
   end

endmodule

// ----- rtl/core/adcavg_queue.sv -----
// two-entry queue of pending display updates between front and back
// depends on adcavg_pkg and assert_macros.svh
`include "assert_macros.svh"
module adcavg_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  adcavg_pkg::burst_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output adcavg_pkg::burst_type head
);
   import adcavg_pkg::*;

   burst_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head       = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push_valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `ASSERT_IMPLIES(q_no_overflow, clock, reset, push_valid, count_ff != 2'd2)
   `ASSERT_IMPLIES(q_no_underflow, clock, reset, pop, count_ff != 2'd0)
   `ASSERT_IMPLIES(q_count_bound, clock, reset, 1'b1, count_ff != 2'd3)

endmodule

// ----- rtl/core/adcavg_back.sv -----
// back end: plays each queued update out as a seven-beat lcd byte burst
// depends on adcavg_pkg and assert_macros.svh; drained from adcavg_queue
`include "assert_macros.svh"
module adcavg_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  adcavg_pkg::burst_type             head,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [adcavg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import adcavg_pkg::*;

   logic [BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [BYTE_W-1:0]     byte_ff, byte_in;
   logic [DISP_W-1:0]     temp_ff;
   logic                  rs_ff, rs_in;
   logic                  last_ff, last_in;
   logic                  load;
   logic [3:0]            tens;
   logic [DISP_W-1:0]     ones;

   assign load = head_valid & (~valid_ff | rsp_tready);
   assign pop  = load & (idx_ff == BYTE_CLOSE);

   // digits of the displayed value
   assign tens = tens_digit(head.temperature);
   assign ones = head.temperature - DISP_W'(tens) * DISP_W'(10);

   // byte for the current beat of the burst
   always_comb begin
      rs_in   = 1'b1;
      last_in = 1'b0;
      case (idx_ff)
         BYTE_CMD: begin
            rs_in   = 1'b0;
            byte_in = LCD_SET_CURSOR | BYTE_W'(head.cursor);
         end
         BYTE_TENS:   byte_in = CHAR_ZERO + BYTE_W'(tens);
         BYTE_ONES:   byte_in = CHAR_ZERO + BYTE_W'(ones);
         BYTE_SPACE:  byte_in = CHAR_SPACE;
         BYTE_OPEN:   byte_in = CHAR_OPEN;
         BYTE_LETTER: byte_in = CHAR_C;
         BYTE_CLOSE: begin
            byte_in = CHAR_CLOSE;
            last_in = 1'b1;
         end
         default:     byte_in = CHAR_SPACE;
      endcase
   end

   // beat counter and output valid
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = (idx_ff == BYTE_CLOSE) ? BYTE_CMD : idx_ff + 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= BYTE_CMD;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         temp_ff <= head.temperature;
         rs_ff   <= rs_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({temp_ff, byte_ff});
   assign rsp_tuser  = rs_ff;
   assign rsp_tlast  = last_ff;

   `ASSERT_IMPLIES(bk_mid_burst_has_entry, clock, reset, idx_ff != BYTE_CMD, head_valid)
   `ASSERT_IMPLIES(bk_last_ends_burst, clock, reset, valid_ff && last_ff, idx_ff == BYTE_CMD)
   `ASSERT_IMPLIES(bk_cmd_has_bit7, clock, reset, valid_ff && !rs_ff, byte_ff[BYTE_W-1])

endmodule

// ----- rtl/core/adc_average_temperature_lcd_writer_unit.sv -----
// top level of the averaging temperature lcd writer: csr registers, front, queue, back
// depends on adcavg_pkg, adcavg_front, adcavg_queue and adcavg_back
//
// channel  direction  beat contents
// req      in         tdata[9:0] adc_sample
// rsp      out        tdata[7:0] lcd_byte, tdata[14:8] temperature; tuser register_select;
//                     tlast last
// csr      in         csr_index register number, csr_data value
//
// a sample is taken every cycle while the front's single stage is free or moving on;
// a sample that changes the displayed value yields a 7-beat burst, one beat a cycle while
// the rsp side is ready.
// the two-entry queue lets the front keep taking samples while a burst plays out.
// synchronous reset clears control, accumulator and display state, scale 300, cursor 70.
// a stalled rsp beat holds; csr writes are always ready.
module adc_average_temperature_lcd_writer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [adcavg_pkg::REQ_DATA_W-1:0]    req_tdata,   // [9:0] adc_sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [adcavg_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [7:0] lcd_byte, [14:8] temperature
   output logic                                 rsp_tuser,   // [0] register_select
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [adcavg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [adcavg_pkg::CSR_DATA_W-1:0]    csr_data
);
   import adcavg_pkg::*;

   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic                csr_write;
   logic                push_valid;
   burst_type           push_entry;
   logic                queue_full;
   logic                pop;
   logic                head_valid;
   burst_type           head;

   // configuration registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      scale_in  = scale_ff;
      cursor_in = cursor_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SCALE_FACTOR:   scale_in  = csr_data[SCALE_W-1:0];
            CSR_CURSOR_ADDRESS: cursor_in = csr_data[CURSOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         cursor_ff <= CURSOR_RESET;
      end else begin
         scale_ff  <= scale_in;
         cursor_ff <= cursor_in;
      end
   end

   adcavg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .scale_factor   (scale_ff),
      .cursor_address (cursor_ff),
      .push_valid     (push_valid),
      .push_entry     (push_entry),
      .queue_full     (queue_full)
   );

   adcavg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   adcavg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
